FILE: rtl/mts_pkg.sv
package mts_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS  = 16;
  localparam int PHASE_W    = 19;
  localparam int POS_W      = 17;
  localparam int RATIO_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Internal widths
  localparam int T_W   = FRAC_BITS + 1;      // clamped phase, 0..ONE
  localparam int TA_W  = FRAC_BITS;          // clamped acceleration ratio
  localparam int VM_W  = FRAC_BITS + 1;      // cruise velocity, below 2*ONE
  localparam int K_W   = FRAC_BITS + 7;      // ramp curvature vm/(2*ta)
  localparam int M_W   = T_W + 1;            // 2t - ta
  localparam int C_W   = FRAC_BITS + 5;      // quintic inner polynomial
  localparam int P_W   = T_W + K_W;          // shared multiplier product
  localparam int R_W   = P_W + 1 - FRAC_BITS;
  localparam int MJ_W  = T_W + C_W;
  localparam int DIV_W = 2 * FRAC_BITS + 2;  // divider dividend / quotient
  localparam int DVS_W = FRAC_BITS + 1;      // divider divisor
  localparam int CNT_W = $clog2(DIV_W);

  localparam longint ONE_I   = longint'(1) << FRAC_BITS;
  localparam longint HALF_I  = longint'(1) << (FRAC_BITS - 1);
  localparam longint TA_LO_I = (ONE_I * 1 + 50) / 100;
  localparam longint TA_HI_I = (ONE_I * 49 + 50) / 100;
  localparam longint ACCEL_RESET_I = 16384;

  localparam logic [T_W-1:0]  ONE   = T_W'(ONE_I);
  localparam logic [TA_W-1:0] TA_LO = TA_W'(TA_LO_I);
  localparam logic [TA_W-1:0] TA_HI = TA_W'(TA_HI_I);
  localparam logic [TA_W-1:0] TA_RESET =
    (ACCEL_RESET_I < TA_LO_I) ? TA_LO :
    (ACCEL_RESET_I > TA_HI_I) ? TA_HI : TA_W'(ACCEL_RESET_I);
  localparam logic [C_W-1:0]  C_TEN = C_W'(10 * ONE_I);

  // Profile modes; the unused code runs as linear
  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN_JERK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAPEZOID = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATIO   = 1'b1;

  // Trapezoid segment of a phase
  typedef enum logic [1:0] {
    RG_RAMP_UP,
    RG_CRUISE,
    RG_RAMP_DOWN
  } region_t;

  // Coefficient sequencer states
  typedef enum logic [2:0] {
    CS_LOAD_VM,
    CS_DIV_VM,
    CS_LOAD_K,
    CS_DIV_K,
    CS_STORE_K,
    CS_IDLE
  } coef_state_t;

  // Trapezoid coefficients handed to the datapath
  typedef struct packed {
    logic [TA_W-1:0] ta;
    logic [VM_W-1:0] vm;
    logic [K_W-1:0]  k;
  } coef_t;

endpackage

FILE: rtl/mts_coef.sv
module mts_coef (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ratio_we,
  input  logic [mts_pkg::RATIO_W-1:0]       ratio_data,
  output mts_pkg::coef_t                    coef,
  output logic                              busy
);

  localparam int DIV_W = mts_pkg::DIV_W;
  localparam int DVS_W = mts_pkg::DVS_W;

  mts_pkg::coef_state_t state_r, state_nxt;

  logic [mts_pkg::TA_W-1:0]  ta_r, ta_nxt;
  logic [mts_pkg::VM_W-1:0]  vm_r;
  logic [mts_pkg::K_W-1:0]   k_r;
  logic [DIV_W-1:0]          dvd_r;
  logic [DVS_W-1:0]          dvs_r;
  logic [DVS_W-1:0]          rem_r;
  logic [mts_pkg::CNT_W-1:0] cnt_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_step;
  logic             rem_ge;
  logic             last_step;
  logic [DVS_W-1:0] den;
  logic [DIV_W-1:0] vm_dvd;
  logic [DIV_W-1:0] k_dvd;

  // Clamp the written ratio to the legal acceleration window
  always_comb begin
    if (ratio_data < mts_pkg::RATIO_W'(mts_pkg::TA_LO)) begin
      ta_nxt = mts_pkg::TA_LO;
    end else if (ratio_data > mts_pkg::RATIO_W'(mts_pkg::TA_HI)) begin
      ta_nxt = mts_pkg::TA_HI;
    end else begin
      ta_nxt = ratio_data[mts_pkg::TA_W-1:0];
    end
  end

  // Restoring divide step, one quotient bit per cycle
  assign rem_sh    = {rem_r, dvd_r[DIV_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, dvs_r};
  assign rem_step  = rem_ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
  assign last_step = cnt_r == mts_pkg::CNT_W'(DIV_W - 1);

  // vm = round(ONE*ONE / (ONE - ta)); k = round(vm*ONE / (2*ta))
  assign den    = mts_pkg::ONE - DVS_W'(ta_r);
  assign vm_dvd = (DIV_W'(1) << (2 * mts_pkg::FRAC_BITS)) + DIV_W'(den >> 1);
  assign k_dvd  = (DIV_W'(dvd_r[mts_pkg::VM_W-1:0]) << mts_pkg::FRAC_BITS) + DIV_W'(ta_r);

  // Sequence the two divisions; a ratio write restarts them
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mts_pkg::CS_LOAD_VM: state_nxt = mts_pkg::CS_DIV_VM;
      mts_pkg::CS_DIV_VM: begin
        if (last_step) state_nxt = mts_pkg::CS_LOAD_K;
      end
      mts_pkg::CS_LOAD_K: state_nxt = mts_pkg::CS_DIV_K;
      mts_pkg::CS_DIV_K: begin
        if (last_step) state_nxt = mts_pkg::CS_STORE_K;
      end
      mts_pkg::CS_STORE_K: state_nxt = mts_pkg::CS_IDLE;
      mts_pkg::CS_IDLE:    state_nxt = mts_pkg::CS_IDLE;
      default:             state_nxt = mts_pkg::CS_IDLE;
    endcase
    if (ratio_we) state_nxt = mts_pkg::CS_LOAD_VM;
    busy = state_r != mts_pkg::CS_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mts_pkg::CS_LOAD_VM;
      ta_r    <= mts_pkg::TA_RESET;
    end else begin
      state_r <= state_nxt;
      if (ratio_we) ta_r <= ta_nxt;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    case (state_r) inside
      mts_pkg::CS_LOAD_VM: begin
        dvd_r <= vm_dvd;
        dvs_r <= den;
        rem_r <= '0;
        cnt_r <= '0;
      end
      mts_pkg::CS_DIV_VM, mts_pkg::CS_DIV_K: begin
        dvd_r <= {dvd_r[DIV_W-2:0], rem_ge};
        rem_r <= rem_step[DVS_W-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
      mts_pkg::CS_LOAD_K: begin
        vm_r  <= dvd_r[mts_pkg::VM_W-1:0];
        dvd_r <= k_dvd;
        dvs_r <= {ta_r, 1'b0};
        rem_r <= '0;
        cnt_r <= '0;
      end
      mts_pkg::CS_STORE_K: begin
        k_r <= dvd_r[mts_pkg::K_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign coef.ta = ta_r;
  assign coef.vm = vm_r;
  assign coef.k  = k_r;

endmodule

FILE: rtl/mts_pipe.sv
module mts_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [mts_pkg::PHASE_W-1:0]  in_phase,
  input  logic [mts_pkg::MODE_W-1:0]          mode,
  input  mts_pkg::coef_t                      coef,
  output logic                                out_valid,
  output logic [mts_pkg::POS_W-1:0]           out_position
);

  localparam int FB   = mts_pkg::FRAC_BITS;
  localparam int T_W  = mts_pkg::T_W;
  localparam int K_W  = mts_pkg::K_W;
  localparam int M_W  = mts_pkg::M_W;
  localparam int C_W  = mts_pkg::C_W;
  localparam int P_W  = mts_pkg::P_W;
  localparam int R_W  = mts_pkg::R_W;
  localparam int MJ_W = mts_pkg::MJ_W;

  // Stage 1: clamp and segment
  logic [T_W-1:0]           s1_t_nxt;
  mts_pkg::region_t         s1_rg_nxt;
  logic                     s1_v_r;
  logic [mts_pkg::MODE_W-1:0] s1_mode_r;
  mts_pkg::region_t         s1_rg_r;
  logic [T_W-1:0]           s1_t_r;

  // Stage 2: square
  logic [T_W-1:0]           s2_u;
  logic [2*T_W-1:0]         s2_sq_full;
  logic [2*T_W-1:0]         s2_sq_sum;
  logic [T_W-1:0]           s2_sq_nxt;
  logic [M_W-1:0]           s2_m_nxt;
  logic                     s2_v_r;
  logic [mts_pkg::MODE_W-1:0] s2_mode_r;
  mts_pkg::region_t         s2_rg_r;
  logic [T_W-1:0]           s2_t_r;
  logic [T_W-1:0]           s2_sq_r;
  logic [M_W-1:0]           s2_m_r;

  // Stage 3: shared multiply and quintic polynomial
  logic                     s3_is_mj;
  logic                     s3_cruise;
  logic [T_W-1:0]           s3_mul_a;
  logic [K_W-1:0]           s3_mul_b;
  logic [P_W-1:0]           s3_prod;
  logic [P_W:0]             s3_rnd_sum;
  logic [R_W-1:0]           s3_res_nxt;
  logic [C_W-1:0]           s3_pos;
  logic [C_W-1:0]           s3_neg;
  logic [C_W-1:0]           s3_c_nxt;
  logic                     s3_v_r;
  logic [mts_pkg::MODE_W-1:0] s3_mode_r;
  mts_pkg::region_t         s3_rg_r;
  logic [T_W-1:0]           s3_t_r;
  logic [R_W-1:0]           s3_res_r;
  logic [C_W-1:0]           s3_c_r;

  // Stage 4: final product, select and saturate
  logic [MJ_W-1:0]          s4_mj_prod;
  logic [MJ_W:0]            s4_mj_sum;
  logic [R_W-1:0]           s4_mj;
  logic [R_W-1:0]           s4_down;
  logic [R_W-1:0]           s4_s;
  logic [mts_pkg::POS_W-1:0] pos_nxt;
  logic                     out_valid_r;
  logic [mts_pkg::POS_W-1:0] out_pos_r;

  // Clamp phase to 0..ONE and find the trapezoid segment
  always_comb begin
    if (in_phase[mts_pkg::PHASE_W-1]) begin
      s1_t_nxt = '0;
    end else if (in_phase[mts_pkg::PHASE_W-2:0] > (mts_pkg::PHASE_W-1)'(mts_pkg::ONE_I)) begin
      s1_t_nxt = mts_pkg::ONE;
    end else begin
      s1_t_nxt = in_phase[T_W-1:0];
    end
    if (s1_t_nxt <= T_W'(coef.ta)) begin
      s1_rg_nxt = mts_pkg::RG_RAMP_UP;
    end else if (s1_t_nxt <= mts_pkg::ONE - T_W'(coef.ta)) begin
      s1_rg_nxt = mts_pkg::RG_CRUISE;
    end else begin
      s1_rg_nxt = mts_pkg::RG_RAMP_DOWN;
    end
  end

  // Square t (or ONE - t past the ramp up in trapezoid mode) and form 2t - ta
  assign s2_u = (s1_mode_r == mts_pkg::MODE_TRAPEZOID && s1_rg_r != mts_pkg::RG_RAMP_UP)
                ? mts_pkg::ONE - s1_t_r : s1_t_r;
  assign s2_sq_full = (2*T_W)'(s2_u) * (2*T_W)'(s2_u);
  assign s2_sq_sum  = s2_sq_full + (2*T_W)'(mts_pkg::HALF_I);
  assign s2_sq_nxt  = s2_sq_sum[FB +: T_W];
  assign s2_m_nxt   = {s1_t_r, 1'b0} - M_W'(coef.ta);

  // One multiplier serves t^3, the ramp curvature and the cruise line
  assign s3_is_mj  = s2_mode_r == mts_pkg::MODE_MIN_JERK;
  assign s3_cruise = s2_mode_r == mts_pkg::MODE_TRAPEZOID && s2_rg_r == mts_pkg::RG_CRUISE;
  assign s3_mul_a  = s3_cruise ? T_W'(coef.vm) : s2_sq_r;
  assign s3_mul_b  = s3_is_mj  ? K_W'(s2_t_r) :
                     s3_cruise ? K_W'(s2_m_r) : coef.k;
  assign s3_prod   = P_W'(s3_mul_a) * P_W'(s3_mul_b);
  assign s3_rnd_sum = {1'b0, s3_prod} +
                      (P_W+1)'(s3_cruise ? mts_pkg::ONE_I : mts_pkg::HALF_I);
  assign s3_res_nxt = s3_cruise ? R_W'(s3_rnd_sum[P_W:FB+1]) : s3_rnd_sum[P_W:FB];

  // c = 6*t2 - 15*t + 10, floored at zero
  assign s3_pos   = C_W'({s2_sq_r, 2'b0}) + C_W'({s2_sq_r, 1'b0}) + mts_pkg::C_TEN;
  assign s3_neg   = C_W'({s2_t_r, 4'b0}) - C_W'(s2_t_r);
  assign s3_c_nxt = (s3_pos >= s3_neg) ? s3_pos - s3_neg : '0;

  // Finish the quintic, mirror the ramp down, pick by mode
  assign s4_mj_prod = MJ_W'(s3_res_r[T_W-1:0]) * MJ_W'(s3_c_r);
  assign s4_mj_sum  = {1'b0, s4_mj_prod} + (MJ_W+1)'(mts_pkg::HALF_I);
  assign s4_mj      = R_W'(s4_mj_sum[MJ_W:FB]);
  assign s4_down    = (s3_res_r > R_W'(mts_pkg::ONE_I)) ? '0 : R_W'(mts_pkg::ONE_I) - s3_res_r;

  always_comb begin
    case (s3_mode_r)
      mts_pkg::MODE_MIN_JERK:  s4_s = s4_mj;
      mts_pkg::MODE_TRAPEZOID: s4_s = (s3_rg_r == mts_pkg::RG_RAMP_DOWN) ? s4_down : s3_res_r;
      default:                 s4_s = R_W'(s3_t_r);
    endcase
    if (s4_s > R_W'(mts_pkg::ONE_I)) begin
      pos_nxt = mts_pkg::POS_W'(mts_pkg::ONE_I);
    end else begin
      pos_nxt = s4_s[mts_pkg::POS_W-1:0];
    end
  end

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    s1_mode_r <= mode;
    s1_rg_r   <= s1_rg_nxt;
    s1_t_r    <= s1_t_nxt;

    s2_mode_r <= s1_mode_r;
    s2_rg_r   <= s1_rg_r;
    s2_t_r    <= s1_t_r;
    s2_sq_r   <= s2_sq_nxt;
    s2_m_r    <= s2_m_nxt;

    s3_mode_r <= s2_mode_r;
    s3_rg_r   <= s2_rg_r;
    s3_t_r    <= s2_t_r;
    s3_res_r  <= s3_res_nxt;
    s3_c_r    <= s3_c_nxt;

    out_pos_r <= pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;

endmodule

FILE: rtl/motion_time_scaling_profile.sv
// Normalized trajectory time scaling: phase in, path position out.
//
// Input: a word is taken at each rising edge with start high and busy low.
// in_phase is signed Q16 and is clamped to 0..1.0 before use.
// Output: out_strobe is high for one cycle with out_position (unsigned Q16,
// 0..65536). The receiver cannot stall; every word is presented once.
// A new word may be taken every cycle, through four register stages (clamp,
// square, shared multiply, final multiply and select).
// Configuration: cfg_we writes profile_mode (index 0: linear, minimum jerk,
// trapezoid) or the acceleration ratio (index 1) at the edge. A ratio write
// starts a bit-serial divider that derives the cruise velocity and ramp
// curvature, one quotient bit per cycle; busy is high after the write until
// both coefficients are stored.
// Reset: mode returns to linear and the ratio to 0.25; the same coefficient
// run follows reset, with busy high, and the pipeline is empty.
module motion_time_scaling_profile (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mts_pkg::PHASE_W-1:0]  in_phase,
  output logic                                out_strobe,
  output logic [mts_pkg::POS_W-1:0]           out_position,
  input  logic                                cfg_we,
  input  logic [mts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [mts_pkg::MODE_W-1:0] mode_r;
  logic                       ratio_we;
  logic                       in_valid;
  mts_pkg::coef_t             coef;

  // Hold the profile mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mts_pkg::MODE_LINEAR;
    end else if (cfg_we && cfg_index == mts_pkg::CFG_PROFILE_MODE) begin
      mode_r <= cfg_data[mts_pkg::MODE_W-1:0];
    end
  end

  assign ratio_we = cfg_we && cfg_index == mts_pkg::CFG_RAMP_RATIO;
  assign in_valid = start && !busy;

  mts_coef u_coef (
    .clk        (clk),
    .rst_n      (rst_n),
    .ratio_we   (ratio_we),
    .ratio_data (cfg_data[mts_pkg::RATIO_W-1:0]),
    .coef       (coef),
    .busy       (busy)
  );

  mts_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_phase     (in_phase),
    .mode         (mode_r),
    .coef         (coef),
    .out_valid    (out_strobe),
    .out_position (out_position)
  );

  // A strobe always traces back to an accepted word through the pipeline stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 4))
    else $error("result strobe without matching accepted word");

  // A ratio write must hold off new words while coefficients are rebuilt
  a_ratio_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == mts_pkg::CFG_RAMP_RATIO |=> busy)
    else $error("busy not raised after ratio write");

  // Position never leaves 0..1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_position <= mts_pkg::POS_W'(mts_pkg::ONE_I))
    else $error("position above full scale");

endmodule

FILE: tb/testbench.sv
module testbench;

  typedef longint unsigned u64_t;

  localparam int   FB           = mts_pkg::FRAC_BITS;
  localparam int   PHASE_W      = mts_pkg::PHASE_W;
  localparam int   POS_W        = mts_pkg::POS_W;
  localparam int   RATIO_W      = mts_pkg::RATIO_W;
  localparam int   MODE_W       = mts_pkg::MODE_W;
  localparam int   CFG_IDX_W    = mts_pkg::CFG_IDX_W;
  localparam int   CFG_DATA_W   = mts_pkg::CFG_DATA_W;
  localparam u64_t Q_ONE        = u64_t'(1) << FB;
  localparam u64_t Q_HALF       = u64_t'(1) << (FB - 1);
  localparam int   DRAIN_CYCLES = 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [PHASE_W-1:0]  in_phase = '0;
  logic                       out_strobe;
  logic [POS_W-1:0]           out_position;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Shadow of the configuration and of the derived trapezoid coefficients
  logic [MODE_W-1:0] pm_mode = mts_pkg::MODE_LINEAR;
  u64_t              pm_ta;
  u64_t              pm_vm;
  u64_t              pm_k;

  logic [POS_W-1:0] position_q[$];
  bit               no_gaps = 1'b0;
  int               mismatches = 0;
  int               words_checked = 0;
  int               ratio_writes = 0;
  int               mode_words[4] = '{0, 0, 0, 0};

  motion_time_scaling_profile dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_phase     (in_phase),
    .out_strobe   (out_strobe),
    .out_position (out_position),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

  // Round half up and drop the fraction bits
  function automatic u64_t q_round(input u64_t x);
    return (x + Q_HALF) >> FB;
  endfunction

  // Clamp the ratio and derive cruise velocity and ramp curvature
  function automatic void set_ratio(input logic [RATIO_W-1:0] r);
    u64_t lo;
    u64_t hi;
    u64_t ta;
    u64_t den;
    lo = (Q_ONE + 50) / 100;
    hi = (Q_ONE * 49 + 50) / 100;
    ta = r;
    if (ta < lo) ta = lo;
    if (ta > hi) ta = hi;
    den = Q_ONE - ta;
    pm_ta = ta;
    pm_vm = (Q_ONE * Q_ONE + den / 2) / den;
    pm_k = (pm_vm * Q_ONE + ta) / (2 * ta);
  endfunction

  // Expected path position for one phase under the current configuration
  function automatic logic [POS_W-1:0] scaled_position(input logic signed [PHASE_W-1:0] ph);
    longint v;
    longint c;
    u64_t   t;
    u64_t   s;
    u64_t   t2;
    u64_t   t3;
    u64_t   d;
    u64_t   x;
    v = ph;
    if (v < 0) t = 0;
    else if (v > longint'(Q_ONE)) t = Q_ONE;
    else t = u64_t'(v);
    case (pm_mode)
      mts_pkg::MODE_MIN_JERK: begin
        t2 = q_round(t * t);
        t3 = q_round(t2 * t);
        c = longint'(6 * t2) + longint'(10 * Q_ONE) - longint'(15 * t);
        if (c < 0) c = 0;
        s = q_round(t3 * u64_t'(c));
      end
      mts_pkg::MODE_TRAPEZOID: begin
        if (t <= pm_ta) begin
          s = q_round(q_round(t * t) * pm_k);
        end else if (t <= Q_ONE - pm_ta) begin
          s = (pm_vm * (2 * t - pm_ta) + Q_ONE) / (2 * Q_ONE);
        end else begin
          d = Q_ONE - t;
          x = q_round(q_round(d * d) * pm_k);
          s = (x > Q_ONE) ? 0 : Q_ONE - x;
        end
      end
      default: s = t;
    endcase
    if (s > Q_ONE) s = Q_ONE;
    return s[POS_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // Compare each strobed word with the oldest expected position
  always @(posedge clk) begin
    logic [POS_W-1:0] want;
    if (rst_n && out_strobe) begin
      if (position_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, position %0d", out_position));
      end else begin
        want = position_q.pop_front();
        words_checked++;
        if (out_position !== want)
          report_mismatch($sformatf("position %0d, expected %0d", out_position, want));
      end
    end
  end

  // Offer one phase word after a random gap; hold start until busy is low
  task automatic send_phase(input logic signed [PHASE_W-1:0] ph);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 10));
    repeat (gap) begin
      start = 1'b0;
      in_phase = PHASE_W'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    in_phase = ph;
    @(posedge clk);
    while (busy) @(posedge clk);
    position_q = {position_q, scaled_position(ph)};
    mode_words[pm_mode]++;
    @(negedge clk);
  endtask

  // Drop start and let the pipeline empty
  task automatic wait_idle();
    int guard;
    start = 1'b0;
    guard = 0;
    while (position_q.size() != 0 && guard < 500) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mts_pkg::CFG_PROFILE_MODE) begin
      pm_mode = val[MODE_W-1:0];
    end else begin
      set_ratio(val[RATIO_W-1:0]);
      ratio_writes++;
    end
  endtask

  // Clamping of the phase at both ends of the signed range
  task automatic test_linear_extremes();
    write_register(mts_pkg::CFG_PROFILE_MODE, CFG_DATA_W'(mts_pkg::MODE_LINEAR));
    send_phase(PHASE_W'(-262144));
    send_phase(PHASE_W'(-131072));
    send_phase(PHASE_W'(-1));
    send_phase(PHASE_W'(0));
    send_phase(PHASE_W'(1));
    send_phase(PHASE_W'(65535));
    send_phase(PHASE_W'(65536));
    send_phase(PHASE_W'(65537));
    send_phase(PHASE_W'(262143));
  endtask

  task automatic test_min_jerk_points();
    write_register(mts_pkg::CFG_PROFILE_MODE, CFG_DATA_W'(mts_pkg::MODE_MIN_JERK));
    send_phase(PHASE_W'(-5));
    send_phase(PHASE_W'(1));
    send_phase(PHASE_W'(32768));
    send_phase(PHASE_W'(65535));
    send_phase(PHASE_W'(131072));
  endtask

  // Segment boundaries at the reset ratio and at both clamp bounds
  task automatic test_trapezoid_knees();
    write_register(mts_pkg::CFG_PROFILE_MODE, CFG_DATA_W'(mts_pkg::MODE_TRAPEZOID));
    send_phase(PHASE_W'(16384));
    send_phase(PHASE_W'(49152));
    write_register(mts_pkg::CFG_RAMP_RATIO, '0);
    send_phase(PHASE_W'(pm_ta));
    send_phase(PHASE_W'(pm_ta + 1));
    send_phase(PHASE_W'(Q_ONE - pm_ta));
    send_phase(PHASE_W'(Q_ONE - pm_ta + 1));
    write_register(mts_pkg::CFG_RAMP_RATIO, CFG_DATA_W'(Q_ONE));
    send_phase(PHASE_W'(pm_ta));
    send_phase(PHASE_W'(pm_ta + 1));
    send_phase(PHASE_W'(Q_ONE - pm_ta));
    send_phase(PHASE_W'(Q_ONE - pm_ta + 1));
  endtask

  // The spare mode code runs as linear
  task automatic test_unused_mode();
    write_register(mts_pkg::CFG_PROFILE_MODE, CFG_DATA_W'(MODE_UNUSED));
    send_phase(PHASE_W'(40000));
    send_phase(PHASE_W'(-7));
  endtask

  // Blocks of random phases, each under a fresh mode and usually a fresh ratio
  task automatic test_random_profiles();
    int                         blk;
    int                         n;
    logic [MODE_W-1:0]          mode;
    logic [CFG_DATA_W-1:0]      val;
    logic signed [PHASE_W-1:0]  ph;
    u64_t                       knee;
    for (blk = 0; blk < 14; blk++) begin
      case ($urandom_range(0, 7)) inside
        0:       mode = mts_pkg::MODE_LINEAR;
        [1:3]:   mode = mts_pkg::MODE_MIN_JERK;
        7:       mode = MODE_UNUSED;
        default: mode = mts_pkg::MODE_TRAPEZOID;
      endcase
      val = CFG_DATA_W'($urandom);
      val[MODE_W-1:0] = mode;
      write_register(mts_pkg::CFG_PROFILE_MODE, val);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: begin
            case ($urandom_range(0, 7))
              0:       val = '0;
              1:       val = CFG_DATA_W'(1);
              2:       val = CFG_DATA_W'(654);
              3:       val = CFG_DATA_W'(656);
              4:       val = CFG_DATA_W'(32112);
              5:       val = CFG_DATA_W'(32114);
              6:       val = CFG_DATA_W'(Q_ONE);
              default: val = '1;
            endcase
          end
          1:       val = CFG_DATA_W'($urandom);
          default: val = CFG_DATA_W'($urandom_range(655, 32113));
        endcase
        write_register(mts_pkg::CFG_RAMP_RATIO, val);
      end
      no_gaps = ($urandom_range(0, 2) == 0);
      for (n = 0; n < 45; n++) begin
        case ($urandom_range(0, 19)) inside
          [0:2]: ph = PHASE_W'($urandom);
          [3:4]: begin
            case ($urandom_range(0, 3))
              0:       knee = pm_ta;
              1:       knee = Q_ONE - pm_ta;
              2:       knee = 0;
              default: knee = Q_ONE;
            endcase
            ph = PHASE_W'(longint'(knee) + $urandom_range(0, 4) - 2);
          end
          5: ph = $urandom_range(0, 1) ? PHASE_W'(Q_ONE) : '0;
          default: ph = PHASE_W'($urandom_range(0, 65536));
        endcase
        send_phase(ph);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    set_ratio(RATIO_W'(mts_pkg::ACCEL_RESET_I));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_linear_extremes();
    test_min_jerk_points();
    test_trapezoid_knees();
    test_unused_mode();
    test_random_profiles();
    wait_idle();

    if (position_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", position_q.size()));
    $display("covered %0d linear, %0d min jerk, %0d trapezoid, %0d spare-mode words",
             mode_words[0], mode_words[1], mode_words[2], mode_words[3]);
    $display("%0d ratio writes, %0d words checked, %0d mismatches",
             ratio_writes, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
